// ----- design/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared word type, round constants, initial chaining value, sigma functions
// and control structs for the round unit and the message schedule.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam int ROUNDS = 64;
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam int CHAIN_N = 8;
    localparam int BLOCK_N = 16;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t CHAIN_IV [CHAIN_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t PAD_MARK = 32'h80000000;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [ROUND_W-1:0]   round;
    } rnd_ctrl_t;

    typedef struct packed {
        logic  push;
        logic  shift;
        word_t word;
    } sched_ctrl_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sig0(input word_t x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t sml_sig0(input word_t x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sml_sig1(input word_t x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- design/sha256_hash_engine_unit.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streams big-endian message words, compresses each 64-byte block, pads the
// final word with the configured prefix length and returns the digest.
//
// channel | dir | handshake               | payload
// s_      | in  | s_tvalid / s_tready     | s_tdata, s_tuser (func), s_tlast
// m_      | out | m_tvalid / m_tready     | m_tdata, m_tlast (digest_last)
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_data (prefix_bytes)
//
// A word that does not fill a block is only stored; the sixteenth word of a
// block runs the 64 rounds of the shared round unit, then one chain update.
// A final word pads into one or two blocks, one word per cycle outside compression.
// The digest leaves as eight beats, each held until m_tready.
// s_tready stays low from block fill until the chain update, and from a final
// word until the last digest beat.
// Reset loads the initial chaining value and clears counts and prefix.
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // word_index[2:0], data[34:3], valid_bytes[37:35]
    input  logic [0:0]  s_tuser,   // func[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], digest_index[34:32]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [39:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_COMP   = 3'd2;
    localparam logic [2:0] ST_FINAL  = 3'd3;
    localparam logic [2:0] ST_DIGEST = 3'd4;

    localparam logic [2:0] PH_NONE = 3'd0;
    localparam logic [2:0] PH_MARK = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_LO   = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    localparam logic       FUNC_LOAD   = 1'b1;
    localparam logic [3:0] FILL_LEN_HI = 4'd14;
    localparam logic [3:0] FILL_LAST   = 4'd15;
    localparam logic [2:0] IDX_LAST    = 3'd7;
    localparam logic [2:0] NV_FULL     = 3'd4;
    localparam logic [sha256_pkg::ROUND_W-1:0] ROUND_LAST = '1;

    logic [2:0]                                  state_reg, state_next;
    logic [2:0]                                  phase_reg, phase_next;
    logic [sha256_pkg::ROUND_W-1:0]              round_reg, round_next;
    logic [3:0]                                  fill_reg, fill_next;
    logic [40:0]                                 byte_cnt_reg, byte_cnt_next;
    logic [39:0]                                 prefix_reg, prefix_next;
    logic [2:0]                                  idx_reg, idx_next;
    sha256_pkg::word_t [sha256_pkg::CHAIN_N-1:0] chain_reg, chain_next;
    sha256_pkg::word_t [sha256_pkg::CHAIN_N-1:0] vars;

    logic              in_acc;
    logic              out_acc;
    logic              in_func;
    logic [2:0]        in_widx;
    sha256_pkg::word_t in_data;
    logic [2:0]        in_nv;
    logic [2:0]        nv_clip;
    sha256_pkg::word_t first_pad;
    sha256_pkg::word_t pad_word;
    logic [41:0]       len_bytes;
    logic [44:0]       len_bits;
    logic              push;
    sha256_pkg::word_t push_word;
    logic              block_full;
    sha256_pkg::word_t sched_w;

    sha256_pkg::rnd_ctrl_t   rnd_ctrl;
    sha256_pkg::sched_ctrl_t sched_ctrl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;

    assign in_func = s_tuser[0];
    assign in_widx = s_tdata[2:0];
    assign in_data = s_tdata[34:3];
    assign in_nv   = s_tdata[37:35];
    assign nv_clip = (in_nv > NV_FULL) ? NV_FULL : in_nv;

    assign len_bytes = {2'b00, prefix_reg} + {1'b0, byte_cnt_reg};
    assign len_bits  = {len_bytes, 3'b000};

    always_comb begin
        case (nv_clip)
            3'd0:    first_pad = sha256_pkg::PAD_MARK;
            3'd1:    first_pad = {in_data[31:24], 24'h800000};
            3'd2:    first_pad = {in_data[31:16], 16'h8000};
            3'd3:    first_pad = {in_data[31:8], 8'h80};
            default: first_pad = in_data;
        endcase
    end

    always_comb begin
        case (phase_reg)
            PH_MARK: pad_word = sha256_pkg::PAD_MARK;
            PH_ZERO: pad_word = (fill_reg == FILL_LEN_HI) ? {19'd0, len_bits[44:32]} : '0;
            PH_LO:   pad_word = len_bits[31:0];
            default: pad_word = '0;
        endcase
    end

    always_comb begin
        push      = 1'b0;
        push_word = pad_word;
        if (state_reg == ST_IDLE && in_acc && in_func != FUNC_LOAD) begin
            push      = 1'b1;
            push_word = s_tlast ? first_pad : in_data;
        end else if (state_reg == ST_PAD) begin
            push = 1'b1;
        end
    end

    assign block_full = push && (fill_reg == FILL_LAST);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        round_next    = round_reg;
        fill_next     = push ? fill_reg + 4'd1 : fill_reg;
        byte_cnt_next = byte_cnt_reg;
        prefix_next   = (cfg_valid && cfg_ready) ? cfg_data : prefix_reg;
        idx_next      = idx_reg;
        chain_next    = chain_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_func == FUNC_LOAD) begin
                        chain_next[in_widx] = in_data;
                    end else begin
                        if (s_tlast) begin
                            byte_cnt_next = byte_cnt_reg + {38'd0, nv_clip};
                            phase_next    = (nv_clip == NV_FULL) ? PH_MARK : PH_ZERO;
                            state_next    = ST_PAD;
                        end else begin
                            byte_cnt_next = byte_cnt_reg + 41'd4;
                        end
                        if (block_full) begin
                            state_next = ST_COMP;
                        end
                    end
                end
            end
            ST_PAD: begin
                case (phase_reg)
                    PH_MARK: phase_next = PH_ZERO;
                    PH_ZERO: phase_next = (fill_reg == FILL_LEN_HI) ? PH_LO : PH_ZERO;
                    PH_LO:   phase_next = PH_DONE;
                    default: phase_next = phase_reg;
                endcase
                if (block_full) begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < sha256_pkg::CHAIN_N; i++) begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                if (phase_reg == PH_DONE) begin
                    state_next = ST_DIGEST;
                end else if (phase_reg == PH_NONE) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_DIGEST: begin
                if (out_acc) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == IDX_LAST) begin
                        for (int i = 0; i < sha256_pkg::CHAIN_N; i++) begin
                            chain_next[i] = sha256_pkg::CHAIN_IV[i];
                        end
                        byte_cnt_next = '0;
                        phase_next    = PH_NONE;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_NONE;
            round_reg    <= '0;
            fill_reg     <= '0;
            byte_cnt_reg <= '0;
            prefix_reg   <= '0;
            idx_reg      <= '0;
            for (int i = 0; i < sha256_pkg::CHAIN_N; i++) begin
                chain_reg[i] <= sha256_pkg::CHAIN_IV[i];
            end
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            round_reg    <= round_next;
            fill_reg     <= fill_next;
            byte_cnt_reg <= byte_cnt_next;
            prefix_reg   <= prefix_next;
            idx_reg      <= idx_next;
            chain_reg    <= chain_next;
        end
    end

    assign rnd_ctrl.load  = block_full;
    assign rnd_ctrl.step  = (state_reg == ST_COMP);
    assign rnd_ctrl.round = round_reg;

    assign sched_ctrl.push  = push;
    assign sched_ctrl.shift = (state_reg == ST_COMP);
    assign sched_ctrl.word  = push_word;

    sha256_sched u_sched (
        .aclk  (aclk),
        .ctrl  (sched_ctrl),
        .w_out (sched_w)
    );

    sha256_round u_round (
        .aclk     (aclk),
        .ctrl     (rnd_ctrl),
        .chain_in (chain_reg),
        .w_in     (sched_w),
        .vars_out (vars)
    );

    assign m_tvalid = (state_reg == ST_DIGEST);
    assign m_tdata  = {5'd0, idx_reg, chain_reg[idx_reg]};
    assign m_tlast  = (idx_reg == IDX_LAST);

`ifndef SYNTHESIS
    a_comp_to_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && round_reg == ROUND_LAST) |=> (state_reg == ST_FINAL))
        else $error("compression did not end in chain update");

    a_digest_block_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGEST) |-> (fill_reg == 4'd0 && phase_reg == PH_DONE))
        else $error("digest with partial block");

    a_no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid || state_reg == ST_COMP) |-> !s_tready)
        else $error("input ready while busy");

    a_full_starts_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        block_full |=> (state_reg == ST_COMP && round_reg == '0))
        else $error("full block did not start compression");
`endif

endmodule

// ----- design/sha256_sched.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word shift window: takes block words as they arrive, then expands
// one schedule word per round while handing the oldest word to the round unit.
// ----------------------------------------------------------------------------
module sha256_sched (
    input  logic                    aclk,
    input  sha256_pkg::sched_ctrl_t ctrl,
    output sha256_pkg::word_t       w_out
);

    sha256_pkg::word_t [sha256_pkg::BLOCK_N-1:0] win_reg;
    sha256_pkg::word_t [sha256_pkg::BLOCK_N-1:0] win_next;
    sha256_pkg::word_t                           expand_word;

    always_comb begin
        expand_word = sha256_pkg::sml_sig1(win_reg[14]) + win_reg[9]
                    + sha256_pkg::sml_sig0(win_reg[1]) + win_reg[0];
        win_next = win_reg;
        if (ctrl.push) begin
            win_next = {ctrl.word, win_reg[sha256_pkg::BLOCK_N-1:1]};
        end else if (ctrl.shift) begin
            win_next = {expand_word, win_reg[sha256_pkg::BLOCK_N-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign w_out = win_reg[0];

endmodule

// ----- design/sha256_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables a..h and one compression round, stepped once per cycle on step.
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic                                        aclk,
    input  sha256_pkg::rnd_ctrl_t                       ctrl,
    input  sha256_pkg::word_t [sha256_pkg::CHAIN_N-1:0] chain_in,
    input  sha256_pkg::word_t                           w_in,
    output sha256_pkg::word_t [sha256_pkg::CHAIN_N-1:0] vars_out
);

    sha256_pkg::word_t [sha256_pkg::CHAIN_N-1:0] vars_reg;
    sha256_pkg::word_t [sha256_pkg::CHAIN_N-1:0] vars_next;
    sha256_pkg::word_t                           t1;
    sha256_pkg::word_t                           t2;
    sha256_pkg::word_t                           choose;
    sha256_pkg::word_t                           major;

    always_comb begin
        choose = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        major  = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
               ^ (vars_reg[1] & vars_reg[2]);
        t1 = vars_reg[7] + sha256_pkg::big_sig1(vars_reg[4]) + choose
           + sha256_pkg::ROUND_K[ctrl.round] + w_in;
        t2 = sha256_pkg::big_sig0(vars_reg[0]) + major;
        vars_next = vars_reg;
        if (ctrl.load) begin
            vars_next = chain_in;
        end else if (ctrl.step) begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        vars_reg <= vars_next;
    end

    assign vars_out = vars_reg;

endmodule

// ----- test/tb_sha256_hash_engine_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Streams message words, chaining-word loads and prefix length settings
// into the engine. A local SHA-256 model predicts every digest beat, and each
// beat is checked on arrival. Both stream sides stall in random bursts, with
// a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_sha256_hash_engine_unit;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;
    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [39:0] PREFIX_MAX = 40'hff_ffff_ffff;
    localparam int PHASE_ITEMS = 40;
    localparam int IDLE_PAUSE = 100;
    localparam int END_PAUSE = 200;
    localparam int QUIET_LIMIT = 4000;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // word_index[2:0], data[34:3], valid_bytes[37:35]
    logic [0:0]  s_tuser = '0;    // func[0]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // digest_word[31:0], digest_index[34:32]
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [39:0] cfg_data = '0;

    logic [31:0] chain_q [8];
    logic [31:0] block_q [16];
    logic [3:0]  fill_q;
    logic [40:0] byte_count_q;
    logic [39:0] prefix_q;

    digest_beat_t pending_digest [$];

    bit idle_en = 1'b1;
    int errors = 0;
    int items_sent = 0;
    int loads_sent = 0;
    int digests_predicted = 0;
    int beats_seen = 0;
    int prefix_writes = 0;
    int rx_hold = 0;
    int quiet_cycles = 0;

    sha256_hash_engine_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        logic [63:0] both;
        both = {x, x} >> n;
        return both[31:0];
    endfunction

    function automatic void compress_chain();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = block_q[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + SHA_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
        chain_q[4] += e; chain_q[5] += f; chain_q[6] += g; chain_q[7] += h;
    endfunction

    function automatic void append_word(input logic [31:0] w);
        block_q[fill_q] = w;
        fill_q = fill_q + 4'd1;
        if (fill_q == 4'd0) compress_chain();
    endfunction

    function automatic void hash_item(input logic func, input logic [2:0] idx,
                                      input logic [31:0] data, input logic [2:0] vb,
                                      input logic last);
        int n;
        logic [31:0] keep;
        logic [63:0] bit_len;
        digest_beat_t beat;
        if (func == FUNC_LOAD) begin
            chain_q[idx] = data;
            return;
        end
        if (!last) begin
            append_word(data);
            byte_count_q = byte_count_q + 41'd4;
            return;
        end
        n = (vb > 3'd4) ? 4 : int'(vb);
        if (n == 4) begin
            append_word(data);
            append_word(PAD_WORD);
        end else begin
            keep = (n == 0) ? 32'h0 : ~(32'hffff_ffff >> (8 * n));
            append_word((data & keep) | (PAD_WORD >> (8 * n)));
        end
        byte_count_q = byte_count_q + 41'(n);
        while (fill_q != 4'd14) append_word(32'h0);
        bit_len = (64'(prefix_q) + 64'(byte_count_q)) << 3;
        append_word(bit_len[63:32]);
        append_word(bit_len[31:0]);
        for (int i = 0; i < 8; i++) begin
            beat.word = chain_q[i];
            beat.index = 3'(i);
            beat.last = (i == 7);
            pending_digest = {pending_digest, beat};
        end
        for (int i = 0; i < 8; i++) chain_q[i] = SHA_IV[i];
        fill_q = '0;
        byte_count_q = '0;
        digests_predicted++;
    endfunction

    initial begin
        for (int i = 0; i < 8; i++) chain_q[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++) block_q[i] = '0;
        fill_q = '0;
        byte_count_q = '0;
        prefix_q = '0;
    end

    task automatic send_beat(input logic func, input logic [2:0] idx, input logic [31:0] data,
                             input logic [2:0] vb, input logic last);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tlast <= last;
        s_tdata <= {2'b00, vb, data, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hash_item(func, idx, data, vb, last);
        items_sent++;
        if (func == FUNC_LOAD) loads_sent++;
    endtask

    task automatic send_message(input int n_body, input logic [2:0] vb, input bit with_loads);
        for (int i = 0; i < n_body; i++) begin
            if (with_loads && $urandom_range(0, 7) == 0) begin
                send_beat(FUNC_LOAD, 3'($urandom_range(0, 7)), $urandom,
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
            send_beat(FUNC_DATA, 3'($urandom_range(0, 7)), $urandom,
                      3'($urandom_range(0, 7)), 1'b0);
        end
        send_beat(FUNC_DATA, 3'($urandom_range(0, 7)), $urandom, vb, 1'b1);
    endtask

    // hold until every digest beat is back and the engine has gone quiet
    task automatic settle(input int pause);
        s_tvalid <= 1'b0;
        while (pending_digest.size() != 0) @(posedge aclk);
        repeat (pause) @(posedge aclk);
    endtask

    task automatic write_prefix(input logic [39:0] value);
        settle(IDLE_PAUSE);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        prefix_q = value;
        prefix_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_final_word_bytes();
        send_beat(FUNC_DATA, 3'd7, 32'hffff_ffff, 3'd0, 1'b1);
        send_beat(FUNC_DATA, 3'd0, 32'hffff_ffff, 3'd1, 1'b1);
        send_beat(FUNC_DATA, 3'd5, 32'h0000_0000, 3'd3, 1'b1);
        send_beat(FUNC_DATA, 3'd2, $urandom, 3'd7, 1'b1);
    endtask

    task automatic test_chain_load();
        send_beat(FUNC_LOAD, 3'd0, 32'hffff_ffff, 3'd7, 1'b1);
        send_beat(FUNC_LOAD, 3'd7, 32'h0000_0000, 3'd0, 1'b0);
        send_beat(FUNC_DATA, 3'd1, $urandom, 3'd4, 1'b1);
        // load in the middle of a message
        send_beat(FUNC_DATA, 3'd6, $urandom, 3'd0, 1'b0);
        send_beat(FUNC_LOAD, 3'd3, $urandom, 3'd4, 1'b1);
        send_beat(FUNC_DATA, 3'd0, $urandom, 3'd2, 1'b1);
    endtask

    task automatic test_padding_tail();
        send_message(13, 3'd4, 1'b0);
    endtask

    task automatic test_prefix_extremes();
        write_prefix(PREFIX_MAX);
        send_message(1, 3'd2, 1'b0);
    endtask

    task automatic test_random_traffic();
        int target;
        int n;
        logic [2:0] vb;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_prefix(40'({$urandom, $urandom}));
                1: write_prefix(PREFIX_MAX);
                2: write_prefix(40'($urandom_range(0, 1000)));
                default: begin
                    write_prefix('0);
                    idle_en = 1'b0;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                vb = 3'($urandom_range(0, 7));
                case ($urandom_range(0, 4))
                    0: begin
                        // whole blocks: padding lands in a fresh block
                        n = 15 + $urandom_range(0, 1);
                        vb = (n == 15) ? 3'($urandom_range(4, 7)) : 3'd0;
                    end
                    1: n = $urandom_range(13, 14);
                    2, 3: n = $urandom_range(0, 12);
                    default: n = $urandom_range(17, 31);
                endcase
                send_message(n, vb, 1'b1);
            end
        end
    endtask

    always @(posedge aclk) begin : rx
        digest_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (pending_digest.size() == 0) begin
                $display("%0t: unexpected digest beat: expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = pending_digest.pop_front();
                if (m_tdata[31:0] !== want.word) begin
                    $display("%0t: digest_word mismatch: expected %h, actual %h",
                             $time, want.word, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[34:32] !== want.index) begin
                    $display("%0t: digest_index mismatch: expected %0d, actual %0d",
                             $time, want.index, m_tdata[34:32]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: digest_last mismatch: expected %b, actual %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
        if (rx_hold == 0 && idle_en && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 12);
        end
        m_tready <= (rx_hold == 0);
        if (rx_hold > 0) rx_hold--;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : main
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_final_word_bytes();
        test_chain_load();
        test_padding_tail();
        test_prefix_extremes();
        test_random_traffic();
        settle(END_PAUSE);
        $display("covered %0d input beats (%0d chain loads), %0d digests, %0d beats checked",
                 items_sent, loads_sent, digests_predicted, beats_seen);
        $display("prefix length written %0d times, zero and all-ones included", prefix_writes);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
